// File: rtl/mma_pkg.sv
// Shared types and constants for the matrix multiply-accumulate block.
package mma_pkg;

  localparam int VAL_W  = 16;
  localparam int PROD_W = 32;
  localparam int RES_W  = 40;
  localparam int COL_W  = 4;
  localparam int ROWS_W = 16;
  localparam int INNER_W = 7;
  localparam int COLS_W = 5;
  localparam int CFG_DW = 16;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_INNER_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OUT_COLS   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT  = 2'd2;

  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [CFG_IW-1:0]        cfg_idx_t;
  typedef logic [CFG_DW-1:0]        cfg_data_t;

endpackage

// File: rtl/matrix_multiply_accumulate_top.sv
// Top level of the matrix multiply-accumulate block: B store, column MACs and row emitter.
//
// Channel   Ports                                         Direction
// input     start, busy, in_operation, in_value           in (busy out)
// result    out_valid, out_result, out_column,
//           out_last_in_row, out_last_in_matrix           out
// config    cfg_we, cfg_index, cfg_data                   in
//
// One input transaction per cycle while busy is low; the B store is banked by address low bits
// so all columns are read in the same cycle. A row's last A element passes the input and RAM
// read, product, emitter buffer and output registers to the row's first result; the emitter
// then sends one column per cycle, so while the next A element would end a row, every input
// transaction waits until the gap counter set at the previous row-ending element reaches zero.
// Reset is synchronous; busy is high during reset. Results cannot be stalled.
module matrix_multiply_accumulate_top #(
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  mma_pkg::val_t       in_value,
  output logic                out_valid,
  output mma_pkg::res_t       out_result,
  output mma_pkg::col_t       out_column,
  output logic                out_last_in_row,
  output logic                out_last_in_matrix,
  input  logic                cfg_we,
  input  mma_pkg::cfg_idx_t   cfg_index,
  input  mma_pkg::cfg_data_t  cfg_data
);
  import mma_pkg::*;

  localparam int DEPTH = MAX_INNER * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int LB    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NB    = 2 ** LB;
  localparam int BD    = (DEPTH + NB - 1) / NB;
  localparam int RW    = (BD > 1) ? $clog2(BD) : 1;
  localparam int IIW   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int EIW   = $clog2(MAX_INNER + 1);
  localparam int ECW   = $clog2(MAX_COLS + 1);

  logic [INNER_W-1:0] inner_size_r;
  logic [COLS_W-1:0]  out_cols_r;
  logic [ROWS_W-1:0]  row_count_r;

  logic [AW-1:0]      wi_r;
  logic [IIW-1:0]     inner_index_r;
  logic [ROWS_W-1:0]  row_index_r;
  logic [ECW-1:0]     gap_r;

  logic [EIW-1:0]     eff_inner_c;
  logic [ECW-1:0]     eff_cols_c;
  logic               row_end_c;
  logic               last_row_c;
  logic               acc_in;
  logic               load_b;
  logic               stream_a;
  logic [PW-1:0]      ic_c;
  logic [PW-1:0]      wi_inc_c;
  logic [AW-1:0]      base_c;
  logic [RW-1:0]      base_row_c;
  logic [LB-1:0]      off_c;
  logic [RW-1:0]      wrow_c;
  logic [LB-1:0]      wbank_c;

  val_t               rd [NB];

  logic               s1_vld_r;
  val_t               s1_val_r;
  logic [LB-1:0]      s1_off_r;
  logic [ECW-1:0]     s1_cols_r;
  logic               s1_end_r;
  logic               s1_lastrow_r;

  logic               s2_vld_r;
  prod_t              prod_r [MAX_COLS];
  logic [ECW-1:0]     s2_cols_r;
  logic               s2_end_r;
  logic               s2_lastrow_r;

  res_t               acc_r [MAX_COLS];
  res_t               sum_c [MAX_COLS];

  res_t               buf_r [MAX_COLS];
  res_t               buf_nxt [MAX_COLS];
  logic [ECW-1:0]     emit_cnt_r;
  logic [ECW-1:0]     emit_cnt_nxt;
  col_t               emit_col_r;
  col_t               emit_col_nxt;
  logic               emit_lastrow_r;
  logic               emit_lastrow_nxt;
  logic               emit_load_c;

  always_comb begin
    if (inner_size_r == '0) begin
      eff_inner_c = EIW'(1);
    end else if (int'(inner_size_r) > MAX_INNER) begin
      eff_inner_c = EIW'(MAX_INNER);
    end else begin
      eff_inner_c = EIW'(inner_size_r);
    end
    if (out_cols_r == '0) begin
      eff_cols_c = ECW'(1);
    end else if (int'(out_cols_r) > MAX_COLS) begin
      eff_cols_c = ECW'(MAX_COLS);
    end else begin
      eff_cols_c = ECW'(out_cols_r);
    end
  end

  assign row_end_c  = (EIW'(inner_index_r) + EIW'(1)) >= eff_inner_c;
  assign last_row_c = row_index_r == (row_count_r - ROWS_W'(1));
  assign busy       = !rst_n || ((gap_r != '0) && row_end_c);
  assign acc_in     = start && !busy;
  assign load_b     = acc_in && (in_operation == OP_LOAD_B);
  assign stream_a   = acc_in && (in_operation == OP_STREAM_A);

  assign ic_c       = PW'(eff_inner_c * eff_cols_c);
  assign wi_inc_c   = PW'(wi_r) + PW'(1);
  assign base_c     = AW'(inner_index_r * eff_cols_c);
  assign base_row_c = RW'(base_c >> LB);
  assign off_c      = base_c[LB-1:0];
  assign wrow_c     = RW'(wi_r >> LB);
  assign wbank_c    = wi_r[LB-1:0];

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [RW-1:0] raddr;
    logic [VAL_W-1:0] rdata;
    assign raddr = base_row_c + RW'(LB'(b) < off_c);
    assign rd[b] = rdata;
    mma_ram #(
      .WIDTH(VAL_W),
      .DEPTH(BD)
    ) u_ram (
      .clk  (clk),
      .we   (load_b && (wbank_c == LB'(b))),
      .waddr(wrow_c),
      .wdata(in_value),
      .raddr(raddr),
      .rdata(rdata)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_size_r  <= INNER_W'(1);
      out_cols_r    <= COLS_W'(16);
      row_count_r   <= ROWS_W'(1);
      wi_r          <= '0;
      inner_index_r <= '0;
      row_index_r   <= '0;
      gap_r         <= '0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INNER_SIZE: inner_size_r <= cfg_data[INNER_W-1:0];
          CFG_OUT_COLS:   out_cols_r   <= cfg_data[COLS_W-1:0];
          CFG_ROW_COUNT:  row_count_r  <= cfg_data[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (load_b) begin
        wi_r <= (wi_inc_c >= ic_c) ? '0 : AW'(wi_inc_c);
      end
      if (stream_a) begin
        if (row_end_c) begin
          inner_index_r <= '0;
          row_index_r   <= last_row_c ? '0 : row_index_r + ROWS_W'(1);
        end else begin
          inner_index_r <= inner_index_r + IIW'(1);
        end
      end
      if (stream_a && row_end_c) begin
        gap_r <= eff_cols_c - ECW'(1);
      end else if (gap_r != '0) begin
        gap_r <= gap_r - ECW'(1);
      end
      s1_vld_r <= stream_a;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_val_r     <= in_value;
    s1_off_r     <= off_c;
    s1_cols_r    <= eff_cols_c;
    s1_end_r     <= row_end_c;
    s1_lastrow_r <= last_row_c;
    for (int j = 0; j < MAX_COLS; j++) begin
      prod_r[j] <= s1_val_r * rd[s1_off_r + LB'(j)];
    end
    s2_cols_r    <= s1_cols_r;
    s2_end_r     <= s1_end_r;
    s2_lastrow_r <= s1_lastrow_r;
  end

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      sum_c[j] = acc_r[j] + RES_W'(prod_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        acc_r[j] <= '0;
      end
    end else if (s2_vld_r) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (ECW'(j) < s2_cols_r) begin
          acc_r[j] <= s2_end_r ? '0 : sum_c[j];
        end
      end
    end
  end

  assign emit_load_c = s2_vld_r && s2_end_r;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      if (emit_load_c) begin
        buf_nxt[j] = sum_c[j];
      end else if (j + 1 < MAX_COLS) begin
        buf_nxt[j] = buf_r[j+1];
      end else begin
        buf_nxt[j] = buf_r[j];
      end
    end
    emit_cnt_nxt     = emit_cnt_r;
    emit_col_nxt     = emit_col_r;
    emit_lastrow_nxt = emit_lastrow_r;
    if (emit_load_c) begin
      emit_cnt_nxt     = s2_cols_r;
      emit_col_nxt     = '0;
      emit_lastrow_nxt = s2_lastrow_r;
    end else if (emit_cnt_r != '0) begin
      emit_cnt_nxt = emit_cnt_r - ECW'(1);
      emit_col_nxt = emit_col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      emit_cnt_r <= emit_cnt_nxt;
      out_valid  <= emit_cnt_r != '0;
    end
  end

  always_ff @(posedge clk) begin
    buf_r              <= buf_nxt;
    emit_col_r         <= emit_col_nxt;
    emit_lastrow_r     <= emit_lastrow_nxt;
    out_result         <= buf_r[0];
    out_column         <= emit_col_r;
    out_last_in_row    <= emit_cnt_r == ECW'(1);
    out_last_in_matrix <= (emit_cnt_r == ECW'(1)) && emit_lastrow_r;
  end

  a_row_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_in_row |=> out_valid && (out_column == $past(out_column) + 4'd1))
    else $error("result row interrupted or columns out of order");

  a_matrix_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_matrix |-> out_last_in_row)
    else $error("last_in_matrix without last_in_row");

  a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load_c |-> (emit_cnt_r <= ECW'(1)))
    else $error("row loaded into emitter before previous row drained");

  a_first_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load_c |=> ##1 out_valid && (out_column == '0))
    else $error("row emission did not start at column zero");

endmodule

// File: rtl/mma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: tb/matrix_multiply_accumulate_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply-accumulate block, with a predictor of C rows.
module matrix_multiply_accumulate_top_tb;
  import mma_pkg::*;

  localparam int MAX_INNER     = 64;
  localparam int MAX_COLS      = 16;
  localparam int STORE_DEPTH   = MAX_INNER * MAX_COLS;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIR_N         = 14;
  localparam int N_PHASES      = 7;

  typedef struct {
    res_t result;
    col_t column;
    logic last_in_row;
    logic last_in_matrix;
  } c_elem_t;

  typedef struct packed {
    logic op;
    val_t value;
    logic typed;
    res_t exp_result;
    logic exp_last;
  } dir_row_t;

  // Directed rows run with inner_size 2, out_cols 1 and row_count 2.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    {OP_LOAD_B,   16'sh8000, 1'b0, 40'sd0, 1'b0},
    {OP_LOAD_B,   16'sh8000, 1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sh8000, 1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sh8000, 1'b1, 40'sd2147483648, 1'b0},
    {OP_STREAM_A, 16'sh7FFF, 1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sh7FFF, 1'b1, -40'sd2147418112, 1'b1},
    {OP_LOAD_B,   16'sh7FFF, 1'b0, 40'sd0, 1'b0},
    {OP_LOAD_B,   16'shFFFF, 1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sh8000, 1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sh8000, 1'b1, -40'sd1073676288, 1'b0},
    {OP_STREAM_A, 16'sd256,  1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sd1,    1'b1, 40'sd8388351, 1'b1},
    {OP_STREAM_A, 16'sd0,    1'b0, 40'sd0, 1'b0},
    {OP_STREAM_A, 16'sd0,    1'b1, 40'sd0, 1'b0}
  };

  localparam cfg_data_t PH_INNER [N_PHASES] =
    '{16'd4, 16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd5, 16'd2};
  localparam cfg_data_t PH_COLS [N_PHASES] =
    '{16'd16, 16'd1, 16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd4};
  localparam cfg_data_t PH_ROWS [N_PHASES] =
    '{16'd2, 16'd1, 16'd0, 16'd3, 16'd4, 16'hFFFF, 16'd1};
  localparam int PH_ITEMS [N_PHASES] = '{18, 10, 10, 64, 16, 17, 10};
  localparam int PH_IDLE [N_PHASES]  = '{15, 15, 15, 63, 63, 0, 0};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      in_operation;
  val_t      in_value;
  logic      out_valid;
  res_t      out_result;
  col_t      out_column;
  logic      out_last_in_row;
  logic      out_last_in_matrix;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  val_t        b_mem [STORE_DEPTH];
  res_t        col_acc [MAX_COLS];
  int          b_wr_ptr;
  int          k_pos;
  logic [15:0] row_pos;
  logic [INNER_W-1:0] inner_reg;
  logic [COLS_W-1:0]  cols_reg;
  logic [15:0]        rows_reg;

  c_elem_t c_elements_q [$];
  int      err_count = 0;
  int      stall_cycles = 0;
  int      sender_idle_pct;

  matrix_multiply_accumulate_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_result         (out_result),
    .out_column         (out_column),
    .out_last_in_row    (out_last_in_row),
    .out_last_in_matrix (out_last_in_matrix),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_inner();
    if (inner_reg == 0) return 1;
    if (inner_reg > MAX_INNER) return MAX_INNER;
    return int'(inner_reg);
  endfunction

  function automatic int eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic val_t pick_element();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic step_matmul(input logic op, input val_t v);
    int      inner;
    int      cols;
    logic    last_row;
    res_t    prod;
    c_elem_t e;
    inner = eff_inner();
    cols = eff_cols();
    if (op == OP_LOAD_B) begin
      b_mem[b_wr_ptr % STORE_DEPTH] = v;
      if (b_wr_ptr + 1 >= inner * cols || b_wr_ptr + 1 >= STORE_DEPTH) b_wr_ptr = 0;
      else b_wr_ptr = b_wr_ptr + 1;
    end else begin
      for (int j = 0; j < cols; j++) begin
        prod = res_t'(v) * res_t'(b_mem[(k_pos * cols + j) % STORE_DEPTH]);
        col_acc[j] = col_acc[j] + prod;
      end
      if (k_pos + 1 < inner) begin
        k_pos = k_pos + 1;
      end else begin
        last_row = (row_pos == rows_reg - 16'd1);
        for (int j = 0; j < cols; j++) begin
          e.result = col_acc[j];
          e.column = col_t'(j);
          e.last_in_row = (j == cols - 1);
          e.last_in_matrix = (j == cols - 1) && last_row;
          c_elements_q.push_back(e);
          col_acc[j] = '0;
        end
        k_pos = 0;
        row_pos = last_row ? 16'd0 : row_pos + 16'd1;
      end
    end
  endtask

  task automatic send_item(input logic op, input val_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    step_matmul(op, v);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (c_elements_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      CFG_INNER_SIZE: inner_reg = d[INNER_W-1:0];
      CFG_OUT_COLS: cols_reg = d[COLS_W-1:0];
      default: rows_reg = d;
    endcase
  endtask

  task automatic configure(input cfg_data_t inner_d, input cfg_data_t cols_d,
                           input cfg_data_t rows_d);
    write_reg(CFG_INNER_SIZE, inner_d);
    write_reg(CFG_OUT_COLS, cols_d);
    write_reg(CFG_ROW_COUNT, rows_d);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_a;
    int r;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_LOAD_B;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INNER_SIZE;
    cfg_data <= '0;
    inner_reg = 1;
    cols_reg = 16;
    rows_reg = 1;
    b_wr_ptr = 0;
    k_pos = 0;
    row_pos = '0;
    foreach (col_acc[j]) col_acc[j] = '0;
    sender_idle_pct = 15;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(16'd2, 16'd1, 16'd2);
    foreach (DIR_TAB[i]) begin
      send_item(DIR_TAB[i].op, DIR_TAB[i].value);
      if (DIR_TAB[i].typed)
        c_elements_q[c_elements_q.size() - 1] =
          '{DIR_TAB[i].exp_result, '0, 1'b1, DIR_TAB[i].exp_last};
    end

    // The first phase loads every store entry that any later phase reads, so no read can hit
    // an unwritten entry. Rows left partial at the end of a phase run on under the next sizes.
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      configure(PH_INNER[p], PH_COLS[p], PH_ROWS[p]);
      sender_idle_pct = PH_IDLE[p];
      repeat (eff_inner() * eff_cols()) send_item(OP_LOAD_B, pick_element());
      n_a = 0;
      while (n_a < PH_ITEMS[p]) begin
        r = $urandom_range(99);
        if (r < 4) begin
          send_item(OP_LOAD_B, pick_element());
        end else if (r < 5) begin
          repeat (eff_inner() * eff_cols()) send_item(OP_LOAD_B, pick_element());
        end else begin
          send_item(OP_STREAM_A, pick_element());
          n_a++;
        end
      end
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    c_elem_t e;
    if (rst_n && out_valid) begin
      if (c_elements_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("Unexpected result transaction: result %0d column %0d", out_result,
                   out_column);
      end else begin
        e = c_elements_q.pop_front();
        if (out_result !== e.result || out_column !== e.column ||
            out_last_in_row !== e.last_in_row || out_last_in_matrix !== e.last_in_matrix) begin
          err_count++;
          if (err_count <= 10)
            $display("Mismatch: expected %0d col %0d row_end %0b mat_end %0b, got %0d %0d %0b %0b",
                     e.result, e.column, e.last_in_row, e.last_in_matrix,
                     out_result, out_column, out_last_in_row, out_last_in_matrix);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/mma_pkg.sv
rtl/mma_ram.sv
rtl/matrix_multiply_accumulate_top.sv
tb/matrix_multiply_accumulate_top_tb.sv
